>>> rtl/prlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prlt_pkg
// Types and constants shared by the prefix rights lookup table modules.
// ----------------------------------------------------------------------------
package prlt_pkg;

    // request kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    // longest legal prefix per family
    localparam logic [7:0] MAX_LEN_V4 = 8'd32;
    localparam logic [7:0] MAX_LEN_V6 = 8'd128;

    typedef struct packed {
        logic [1:0]  kind;
        logic        family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  pfx_len;
        logic [7:0]  source_tag;
        logic        update_right;
        logic [1:0]  mirror_right;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic       update_allowed;
        logic [1:0] mirror_allowed;
    } t_rsp;

    // one stored table entry; rights bit 0 is update, bits 2..1 mirror
    typedef struct packed {
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [7:0]  length;
        logic        family;
        logic [7:0]  source;
        logic [2:0]  rights;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       clear;
        logic       write;
        logic       scan_init;
        logic       scan_step;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_found;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       len_ok;
        logic       empty;
        logic       cmp_valid;
        logic       cmp_last;
        logic       hit;
    } t_dp_status;

endpackage
`default_nettype wire

>>> rtl/prlt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/prlt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prlt_dp
// Datapath: request register, entry count, entry memory, scan address,
// prefix compare and result register.
// ----------------------------------------------------------------------------
module prlt_dp
    import prlt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_req       i_req,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_sts,
    output t_rsp            o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_req            r_req;
    t_rsp            r_rsp;
    t_rsp            n_rsp;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   n_addr;
    logic            r_cmp_valid;
    logic            n_cmp_valid;
    logic            r_cmp_last;
    logic            n_cmp_last;

    t_entry          wr_entry;
    t_entry          rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic [127:0]    mask;
    logic [127:0]    diff;
    logic            full;
    logic            len_ok;

    assign full   = (r_count == CW'(TABLE_DEPTH));
    assign len_ok = r_req.family ? (r_req.pfx_len <= MAX_LEN_V6)
                                 : (r_req.pfx_len <= MAX_LEN_V4);

    always_comb begin
        wr_entry.prefix_high = r_req.addr_high;
        wr_entry.prefix_low  = r_req.addr_low;
        wr_entry.length      = r_req.pfx_len;
        wr_entry.family      = r_req.family;
        wr_entry.source      = r_req.source_tag;
        wr_entry.rights      = {r_req.mirror_right, r_req.update_right};
    end

    prlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign rd_entry = t_entry'(rd_data);

    // top length bits set; shifts of 128 or more leave an all-ones mask
    assign mask = ~({128{1'b1}} >> rd_entry.length);
    assign diff = {r_req.addr_high, r_req.addr_low}
                ^ {rd_entry.prefix_high, rd_entry.prefix_low};

    always_comb begin
        o_sts.kind      = r_req.kind;
        o_sts.full      = full;
        o_sts.len_ok    = len_ok;
        o_sts.empty     = (r_count == '0);
        o_sts.cmp_valid = r_cmp_valid;
        o_sts.cmp_last  = r_cmp_last;
        o_sts.hit       = (rd_entry.family == r_req.family)
                        && (rd_entry.source == r_req.source_tag)
                        && ((diff & mask) == '0);
    end

    always_comb begin
        n_count     = r_count;
        n_addr      = r_addr;
        n_cmp_valid = r_cmp_valid;
        n_cmp_last  = r_cmp_last;
        n_rsp       = r_rsp;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.write) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.scan_init) begin
            n_addr      = AW'(r_count - CW'(1));
            n_cmp_valid = 1'b0;
            n_cmp_last  = 1'b0;
        end else if (i_cmd.scan_step) begin
            // data for the address issued now shows up next cycle
            n_addr      = r_addr - AW'(1);
            n_cmp_valid = 1'b1;
            n_cmp_last  = (r_addr == '0);
        end
        if (i_cmd.res_set) begin
            n_rsp.status         = i_cmd.res_status;
            n_rsp.found          = i_cmd.res_found;
            n_rsp.update_allowed = i_cmd.res_found & rd_entry.rights[0];
            n_rsp.mirror_allowed = i_cmd.res_found ? rd_entry.rights[2:1] : 2'b00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_cmp_last  <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_cmp_last  <= n_cmp_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        r_addr <= n_addr;
        r_rsp  <= n_rsp;
    end

    assign o_rsp = r_rsp;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> (!full && len_ok))
        else $error("entry written into full table or with bad length");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_init |-> (r_count != '0))
        else $error("scan started on empty table");
`endif

endmodule
`default_nettype wire

>>> rtl/prlt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prlt_ctrl
// Controller: request decode, table scan sequencing and result strobe.
// ----------------------------------------------------------------------------
module prlt_ctrl
    import prlt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_sts,
    output t_dp_cmd         o_cmd,
    output logic            o_busy,
    output logic            o_strobe
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (i_sts.kind)
                    KIND_CLEAR: begin
                        o_cmd.clear      = 1'b1;
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = STATUS_OK;
                    end
                    KIND_INSERT: begin
                        o_cmd.res_set = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res_status = STATUS_FULL;
                        end else if (!i_sts.len_ok) begin
                            o_cmd.res_status = STATUS_BAD_LEN;
                        end else begin
                            o_cmd.write      = 1'b1;
                            o_cmd.res_status = STATUS_OK;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (i_sts.empty) begin
                            o_cmd.res_set    = 1'b1;
                            o_cmd.res_status = STATUS_OK;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = STATUS_OK;
                    end
                endcase
            end
            S_SCAN: begin
                // newest entry first, stop at the first hit
                if (i_sts.cmp_valid && i_sts.hit) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = STATUS_OK;
                    o_cmd.res_found  = 1'b1;
                    n_state          = S_RESP;
                end else if (i_sts.cmp_valid && i_sts.cmp_last) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = STATUS_OK;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_RESP);

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> o_busy)
        else $error("request accepted but controller not busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_hit_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.cmp_valid && i_sts.hit) |=> o_strobe)
        else $error("scan hit did not produce a result");
`endif

endmodule
`default_nettype wire

>>> rtl/prefix_rights_lookup_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_rights_lookup_table
// Access-rights table of address-prefix entries with newest-first lookup.
// ----------------------------------------------------------------------------
// usage:
//   a request (i_req) is taken on a clock edge where start is high and busy is
//   low. kinds: clear table, insert entry, lookup address.
//   exactly one result per request is driven on o_rsp for a single cycle,
//   marked by o_valid. the receiver has no way to stall it.
// sequencing:
//   clear and insert: o_valid follows the request through the EXEC and RESP
//   states; the next request is taken only once busy is low again.
//   lookup: entries are read one per cycle from the entry RAM, newest first,
//   so a lookup steps through the n stored entries in turn before o_valid;
//   a hit ends the scan early. no new request is taken while busy is high.
// reset:
//   i_rst_n low on a clock edge empties the table and returns to idle. the
//   entry RAM is not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module prefix_rights_lookup_table
    import prlt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_sts;

    prlt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_strobe (o_valid)
    );

    prlt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire
